// ----- design/tcgr_pkg.sv -----
// Shared types and constants for the text console glyph renderer.
// Used by tcgr_ctrl, tcgr_dpath and text_console_glyph_renderer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package tcgr_pkg;

	// Item opcodes
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PRINT = 1'b1;

	// Control characters
	localparam logic [7:0] CODE_NEWLINE = 8'd10;
	localparam logic [7:0] CODE_RETURN  = 8'd13;

	// Configuration register indexes
	localparam int CFG_INDEX_W = 2;
	localparam logic [CFG_INDEX_W-1:0] CFG_LINE_PITCH = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_TEXT_ROWS  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] CFG_DRAW_COLOR = 2'd2;

	// Register widths and reset values
	localparam int LINE_PITCH_W = 13;
	localparam int TEXT_ROWS_W  = 9;
	localparam int COLOR_W      = 32;
	localparam logic [LINE_PITCH_W-1:0] LINE_PITCH_RST = 13'd1024;
	localparam logic [TEXT_ROWS_W-1:0]  TEXT_ROWS_RST  = 9'd48;
	localparam logic [COLOR_W-1:0]      DRAW_COLOR_RST = 32'hFFFF_FFFF;

	// Text row limit and offset width
	localparam logic [TEXT_ROWS_W-1:0] ROWS_MAX = 9'd256;
	localparam int OFFSET_W = 24;
	localparam int CURSOR_ROW_W = 8;

	typedef struct packed {
		logic       cmd;
		logic [7:0] char_code;
		logic [3:0] glyph_row;
		logic [7:0] row_bits;
	} req_item_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] pixel_offset;
		logic [7:0]          pixel_mask;
		logic [COLOR_W-1:0]  color;
		logic                last;
	} rsp_item_t;

	// Controller to datapath
	typedef struct packed {
		logic load_we;   // write one font row
		logic start;     // latch glyph code and cursor row
		logic base;      // form row-zero offset, advance cursor
		logic newline;   // move cursor down one text row
		logic cret;      // move cursor to column zero
		logic issue;     // read one glyph row into the output pipe
	} ctrl_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic can_issue; // read stage free this cycle
		logic last_row;  // row counter at final glyph row
	} dp_status_t;

endpackage

`default_nettype wire

// ----- design/tcgr_ctrl.sv -----
// Sequencer for the glyph renderer: decodes items and steps the datapath.
// Depends on tcgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcgr_ctrl (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   req_valid,
	output      logic                   req_ready,
	input  wire tcgr_pkg::req_item_t    req,
	output      tcgr_pkg::ctrl_cmd_t    cmd,
	input  wire tcgr_pkg::dp_status_t   status
);
	import tcgr_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_BASE,
		ST_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign req_ready = (state_q == ST_IDLE);
	assign accept    = req_valid && req_ready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req.cmd == CMD_LOAD) begin
						cmd.load_we = 1'b1;
					end else if (req.char_code == CODE_NEWLINE) begin
						cmd.newline = 1'b1;
					end else if (req.char_code == CODE_RETURN) begin
						cmd.cret = 1'b1;
					end else begin
						cmd.start = 1'b1;
					end
				end
			end
			ST_BASE: begin
				cmd.base = 1'b1;
			end
			ST_EMIT: begin
				cmd.issue = status.can_issue;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.start) begin
						state_q <= ST_BASE;
					end
				end
				ST_BASE: begin
					state_q <= ST_EMIT;
				end
				ST_EMIT: begin
					if (cmd.issue && status.last_row) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_start_to_base: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> (state_q == ST_BASE))
		else $error("start not followed by base step");

	a_base_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_BASE) |=> (state_q == ST_EMIT) && !req_ready)
		else $error("base step not followed by row emission");

	a_last_frees_input: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.issue && status.last_row) |=> req_ready)
		else $error("input not reopened after final glyph row");

	a_no_load_during_emit: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load_we && (cmd.issue || cmd.base)))
		else $error("font write overlaps a print");
`endif

endmodule

`default_nettype wire

// ----- design/tcgr_dpath.sv -----
// Datapath for the glyph renderer: config registers, cursor, font store,
// offset arithmetic and the read/output pipe. Depends on tcgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tcgr_dpath #(
	parameter int GLYPH_HEIGHT = 16,
	parameter int GLYPH_COUNT  = 256,
	parameter int MAX_PITCH    = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire tcgr_pkg::req_item_t                 req,
	input  wire tcgr_pkg::ctrl_cmd_t                 cmd,
	output      tcgr_pkg::dp_status_t                status,
	input  wire logic                                cfg_valid,
	input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire logic [31:0]                         cfg_data,
	output      logic                                rsp_valid,
	input  wire logic                                rsp_ready,
	output      tcgr_pkg::rsp_item_t                 rsp
);
	import tcgr_pkg::*;

	localparam int DEPTH   = GLYPH_COUNT * GLYPH_HEIGHT;
	localparam int AW      = $clog2(DEPTH);
	localparam int RW      = $clog2(GLYPH_HEIGHT);
	localparam int PITCH_W = $clog2(MAX_PITCH + 1);
	localparam int COLS_W  = PITCH_W - 3;
	localparam int COL_W   = $clog2(MAX_PITCH / 8);
	localparam int Y_W     = $clog2(256 * GLYPH_HEIGHT);
	localparam logic [RW-1:0] LAST_ROW = RW'(GLYPH_HEIGHT - 1);

	// Configuration
	logic [LINE_PITCH_W-1:0] line_pitch_q;
	logic [TEXT_ROWS_W-1:0]  text_rows_q;
	logic [COLOR_W-1:0]      draw_color_q;

	// Cursor
	logic [COL_W-1:0]        col_q;
	logic [CURSOR_ROW_W-1:0] row_q;

	// Print context
	logic [7:0]          code_q;
	logic                glyph_ok_q;
	logic [Y_W-1:0]      y0_q;
	logic [OFFSET_W-1:0] off_q;
	logic [RW-1:0]       rcnt_q;

	// Read stage and output register
	logic [7:0]          font_mem [0:DEPTH-1];
	logic [7:0]          rd_s1;
	logic [OFFSET_W-1:0] off_s1;
	logic                last_s1;
	logic                ok_s1;
	logic                v_s1;
	logic                out_valid_q;
	rsp_item_t           out_q;

	logic [PITCH_W-1:0]     pitch_eff;
	logic [COLS_W-1:0]      cols_eff;
	logic [TEXT_ROWS_W-1:0] rows_eff;
	logic [COL_W:0]         col_inc;
	logic [TEXT_ROWS_W-1:0] row_inc;
	logic                   col_wrap;
	logic                   row_wrap;
	logic                   move_s1;
	logic                   load_ok;
	logic [AW-1:0]          waddr;
	logic [AW-1:0]          raddr;

	// Effective geometry
	always_comb begin
		if (32'(line_pitch_q) > MAX_PITCH) begin
			pitch_eff = PITCH_W'(MAX_PITCH);
		end else begin
			pitch_eff = PITCH_W'(line_pitch_q);
		end
		cols_eff = pitch_eff[PITCH_W-1:3];
		if (cols_eff == '0) begin
			cols_eff = COLS_W'(1);
		end
		if (text_rows_q == '0) begin
			rows_eff = TEXT_ROWS_W'(1);
		end else if (text_rows_q > ROWS_MAX) begin
			rows_eff = ROWS_MAX;
		end else begin
			rows_eff = text_rows_q;
		end
	end

	assign col_inc  = {1'b0, col_q} + (COL_W+1)'(1);
	assign row_inc  = {1'b0, row_q} + TEXT_ROWS_W'(1);
	assign col_wrap = (16'(col_inc) >= 16'(cols_eff));
	assign row_wrap = (row_inc >= rows_eff);

	assign load_ok = (32'(req.glyph_row) < GLYPH_HEIGHT) && (32'(req.char_code) < GLYPH_COUNT);
	assign waddr   = AW'(32'(req.char_code) * GLYPH_HEIGHT + 32'(req.glyph_row));
	assign raddr   = AW'(32'(code_q) * GLYPH_HEIGHT + 32'(rcnt_q));

	assign move_s1          = v_s1 && (!out_valid_q || rsp_ready);
	assign status.can_issue = !v_s1 || move_s1;
	assign status.last_row  = (rcnt_q == LAST_ROW);

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_pitch_q <= LINE_PITCH_RST;
			text_rows_q  <= TEXT_ROWS_RST;
			draw_color_q <= DRAW_COLOR_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_LINE_PITCH: line_pitch_q <= cfg_data[LINE_PITCH_W-1:0];
				CFG_TEXT_ROWS:  text_rows_q  <= cfg_data[TEXT_ROWS_W-1:0];
				CFG_DRAW_COLOR: draw_color_q <= cfg_data[COLOR_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// Cursor
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (cmd.cret) begin
			col_q <= '0;
		end else if (cmd.newline || (cmd.base && col_wrap)) begin
			if (cmd.base) begin
				col_q <= '0;
			end
			row_q <= row_wrap ? '0 : row_inc[CURSOR_ROW_W-1:0];
		end else if (cmd.base) begin
			col_q <= col_inc[COL_W-1:0];
		end
	end

	// Print context: code, scan line of row zero, running offset
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			code_q     <= req.char_code;
			glyph_ok_q <= (32'(req.char_code) < GLYPH_COUNT);
			y0_q       <= Y_W'(32'(row_q) * GLYPH_HEIGHT);
		end
		if (cmd.base) begin
			off_q <= OFFSET_W'(32'(y0_q) * 32'(pitch_eff) + (32'(col_q) << 3));
		end else if (cmd.issue) begin
			off_q <= off_q + OFFSET_W'(pitch_eff);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rcnt_q <= '0;
		end else if (cmd.start) begin
			rcnt_q <= '0;
		end else if (cmd.issue) begin
			rcnt_q <= rcnt_q + RW'(1);
		end
	end

	// Font store: one write port for loads, one registered read for rows
	always_ff @(posedge clk) begin
		if (cmd.load_we && load_ok) begin
			font_mem[waddr] <= req.row_bits;
		end
		if (cmd.issue) begin
			rd_s1   <= font_mem[raddr];
			off_s1  <= off_q;
			last_s1 <= status.last_row;
			ok_s1   <= glyph_ok_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (cmd.issue) begin
			v_s1 <= 1'b1;
		end else if (move_s1) begin
			v_s1 <= 1'b0;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (move_s1) begin
			out_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (move_s1) begin
			out_q.pixel_offset <= off_s1;
			out_q.pixel_mask   <= ok_s1 ? rd_s1 : 8'd0;
			out_q.color        <= draw_color_q;
			out_q.last         <= last_s1;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

`ifndef ASSERT_OFF
	a_row_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		rcnt_q <= LAST_ROW)
		else $error("glyph row counter past last row");

	a_stage_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s1 && out_valid_q && !rsp_ready) |=> v_s1)
		else $error("read stage dropped while output stalled");
`endif

endmodule

`default_nettype wire

// ----- design/text_console_glyph_renderer.sv -----
// Top level of the text console glyph renderer (8-wide bitmap font).
// Instantiates tcgr_ctrl and tcgr_dpath; depends on tcgr_pkg.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+--------------------------------------
//   req     | in  | req_valid / req_ready | tcgr_pkg::req_item_t (load or print)
//   rsp     | out | rsp_valid / rsp_ready | tcgr_pkg::rsp_item_t (one glyph row)
//   cfg     | in  | cfg_valid / cfg_ready | cfg_index, cfg_data (register write)
//
// Load, newline and carriage return items are handled as they are accepted. A
// printed character is accepted, then its row-zero offset is formed with the
// pitch multiplier, then its rows issue one row per cycle while rsp does not
// stall, through the single read port of the font store. The output register lets the next
// item be accepted while the final row still waits on rsp_ready; stalls on
// rsp back up into the read stage and pause the row issue. Reset clears
// cursor, registers and pipe valids; the font store has no clearing pass and
// holds garbage until loaded.
`timescale 1ns / 1ps
`default_nettype none

module text_console_glyph_renderer #(
	parameter int GLYPH_HEIGHT = 16,
	parameter int GLYPH_COUNT  = 256,
	parameter int MAX_PITCH    = 4096
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             req_valid,
	output      logic                             req_ready,
	input  wire tcgr_pkg::req_item_t              req,
	output      logic                             rsp_valid,
	input  wire logic                             rsp_ready,
	output      tcgr_pkg::rsp_item_t              rsp,
	input  wire logic                             cfg_valid,
	output      logic                             cfg_ready,
	input  wire logic [tcgr_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [31:0]                      cfg_data
);
	import tcgr_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t status;

	// Register writes complete as offered; always take them.
	assign cfg_ready = 1'b1;

	// Decode items, sequence the print steps
	tcgr_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.cmd       (cmd),
		.status    (status)
	);

	// Hold config, cursor and font; emit rows
	tcgr_dpath #(
		.GLYPH_HEIGHT (GLYPH_HEIGHT),
		.GLYPH_COUNT  (GLYPH_COUNT),
		.MAX_PITCH    (MAX_PITCH)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.cmd       (cmd),
		.status    (status),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

// ----- tb/text_console_glyph_renderer_test.sv -----
// Self-checking testbench for text_console_glyph_renderer: loads font rows, prints text
// and checks every glyph row result against an in-bench cursor and font store model.
// Depends on tcgr_pkg and the renderer RTL.
`timescale 1ns / 1ps

module text_console_glyph_renderer_test;
	import tcgr_pkg::*;

	localparam int GLYPH_H       = 16;
	localparam int GLYPH_N       = 256;
	localparam int PITCH_MAX     = 4096;
	localparam int STALL_LIMIT   = 2000;        // cycles with no handshake at all
	localparam int SETTLE_CYCLES = GLYPH_H + 8; // row issue plus pipe, with margin
	localparam int SHORT_ROWS    = 8;           // screen height for the cursor walk

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   req_valid = 1'b0;
	logic                   req_ready;
	req_item_t              req       = '0;
	logic                   rsp_valid;
	logic                   rsp_ready = 1'b0;
	rsp_item_t              rsp;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = CFG_LINE_PITCH;
	logic [31:0]            cfg_data  = '0;

	// Shadow of the register file, updated when a write is accepted
	logic [LINE_PITCH_W-1:0] pitch_shadow = LINE_PITCH_RST;
	logic [TEXT_ROWS_W-1:0]  rows_shadow  = TEXT_ROWS_RST;
	logic [COLOR_W-1:0]      color_shadow = DRAW_COLOR_RST;

	// Shadow of the cursor and the font store
	logic [8:0]              col_pos = '0;
	logic [CURSOR_ROW_W-1:0] row_pos = '0;
	logic [7:0]              font_rows   [GLYPH_N*GLYPH_H];
	bit                      font_loaded [GLYPH_N*GLYPH_H];
	bit                      glyph_ready [GLYPH_N];
	logic [7:0]              printable [$]; // codes with every glyph row loaded

	rsp_item_t pending_rows [$];            // glyph rows still owed by the block

	int send_gap_pct   = 33;
	int recv_stall_pct = 54;
	int error_count    = 0;
	int stall_cycles   = 0;

	always #4 clk = ~clk;

	text_console_glyph_renderer #(
		.GLYPH_HEIGHT(GLYPH_H),
		.GLYPH_COUNT (GLYPH_N),
		.MAX_PITCH   (PITCH_MAX)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.req      (req),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// Print one line per mismatch and count every one.
	task automatic report_mismatch(input string what, input logic [63:0] want, got);
		$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
		error_count++;
	endtask

	// Move the cursor down one text row; wrap to the top past the last row.
	// The row count clamps to 1..256, so a zero register still means one row.
	function automatic void step_text_row();
		int unsigned rows;
		int unsigned next_row;
		rows = (rows_shadow == 0) ? 1 : (rows_shadow > ROWS_MAX) ? ROWS_MAX : rows_shadow;
		next_row = row_pos + 1;
		row_pos = (next_row >= rows) ? '0 : next_row[CURSOR_ROW_W-1:0];
	endfunction

	// Apply one accepted item to the shadow state and queue the rows it causes.
	function automatic void render_item(input req_item_t it);
		int unsigned     pitch;
		int unsigned     cols;
		longint unsigned offset;
		rsp_item_t       row;
		bit              whole;
		if (it.cmd == CMD_LOAD) begin
			font_rows[{it.char_code, it.glyph_row}] = it.row_bits;
			font_loaded[{it.char_code, it.glyph_row}] = 1'b1;
			whole = 1'b1;
			for (int r = 0; r < GLYPH_H; r++)
				whole &= font_loaded[{it.char_code, 4'(r)}];
			// Remember glyphs that are now safe to print
			if (whole && !glyph_ready[it.char_code]) begin
				glyph_ready[it.char_code] = 1'b1;
				printable.push_back(it.char_code);
			end
			return;
		end
		if (it.char_code == CODE_NEWLINE) begin
			step_text_row();
			return;
		end
		if (it.char_code == CODE_RETURN) begin
			col_pos = '0;
			return;
		end
		// Pitch clamps at the top; the cursor is used as is, even off screen
		pitch = (pitch_shadow > PITCH_MAX) ? PITCH_MAX : pitch_shadow;
		for (int r = 0; r < GLYPH_H; r++) begin
			offset = (longint'(row_pos) * GLYPH_H + r) * pitch + longint'(col_pos) * 8;
			row.pixel_offset = offset[OFFSET_W-1:0];
			row.pixel_mask   = font_rows[{it.char_code, 4'(r)}];
			row.color        = color_shadow;
			row.last         = (r == GLYPH_H - 1);
			pending_rows.push_back(row);
		end
		// Advance the column; wrap to the next text row at the end of the line
		cols = pitch / 8;
		if (cols == 0)
			cols = 1;
		if (col_pos + 1 >= cols) begin
			col_pos = '0;
			step_text_row();
		end else begin
			col_pos = col_pos + 1'b1;
		end
	endfunction

	// Offer one item, holding valid and payload until it is accepted. Valid is
	// left high on return so back-to-back items never toggle it within a step;
	// any caller that waits drops it first.
	task automatic send_item(input req_item_t it);
		while ($urandom_range(99) < send_gap_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req       <= it;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		render_item(it);
	endtask

	task automatic load_row(input logic [7:0] code, input logic [3:0] grow,
			input logic [7:0] bits);
		req_item_t it;
		it.cmd       = CMD_LOAD;
		it.char_code = code;
		it.glyph_row = grow;
		it.row_bits  = bits;
		send_item(it);
	endtask

	// Print a code; the load-only fields carry noise the block must ignore.
	task automatic print_code(input logic [7:0] code);
		req_item_t it;
		it.cmd       = CMD_PRINT;
		it.char_code = code;
		it.glyph_row = 4'($urandom_range(15));
		it.row_bits  = 8'($urandom_range(255));
		send_item(it);
	endtask

	// Drop valid, wait for every owed row, then let a trailing load or
	// cursor move finish inside the block.
	task automatic settle();
		req_valid <= 1'b0;
		while (pending_rows.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Write all three registers back to back while the block is idle.
	task automatic set_registers(input logic [LINE_PITCH_W-1:0] pitch,
			input logic [TEXT_ROWS_W-1:0] rows, input logic [COLOR_W-1:0] color);
		logic [31:0]            values [3];
		logic [CFG_INDEX_W-1:0] slots  [3];
		settle();
		values = '{32'(pitch), 32'(rows), color};
		slots  = '{CFG_LINE_PITCH, CFG_TEXT_ROWS, CFG_DRAW_COLOR};
		for (int k = 0; k < 3; k++) begin
			cfg_valid <= 1'b1;
			cfg_index <= slots[k];
			cfg_data  <= values[k];
			@(posedge clk);
			while (!cfg_ready)
				@(posedge clk);
		end
		cfg_valid    <= 1'b0;
		pitch_shadow = pitch;
		rows_shadow  = rows;
		color_shadow = color;
	endtask

	// Pick a register setting, favoring the clamped and wrapping corners.
	task automatic set_random_registers();
		logic [LINE_PITCH_W-1:0] pitch;
		logic [TEXT_ROWS_W-1:0]  rows;
		logic [COLOR_W-1:0]      color;
		case ($urandom_range(4))
			0: pitch = LINE_PITCH_W'($urandom_range(7));
			1: pitch = LINE_PITCH_W'($urandom_range(8, 96));
			2: pitch = LINE_PITCH_W'(PITCH_MAX);
			3: pitch = LINE_PITCH_W'($urandom_range(PITCH_MAX + 1, 8191));
			default: pitch = LINE_PITCH_W'($urandom_range(8191));
		endcase
		case ($urandom_range(4))
			0: rows = '0;
			1: rows = TEXT_ROWS_W'($urandom_range(1, 6));
			2: rows = ROWS_MAX;
			3: rows = TEXT_ROWS_W'($urandom_range(257, 511));
			default: rows = TEXT_ROWS_W'($urandom_range(511));
		endcase
		case ($urandom_range(3))
			0: color = '0;
			1: color = '1;
			default: color = $urandom;
		endcase
		set_registers(pitch, rows, color);
	endtask

	// Check each accepted glyph row against the oldest one owed; randomize ready.
	always @(posedge clk) begin
		rsp_item_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (pending_rows.size() == 0) begin
				report_mismatch("unrequested row offset", '0, rsp.pixel_offset);
			end else begin
				want = pending_rows.pop_front();
				if (rsp.pixel_offset !== want.pixel_offset)
					report_mismatch("pixel_offset", want.pixel_offset, rsp.pixel_offset);
				if (rsp.pixel_mask !== want.pixel_mask)
					report_mismatch("pixel_mask", want.pixel_mask, rsp.pixel_mask);
				if (rsp.color !== want.color)
					report_mismatch("color", want.color, rsp.color);
				if (rsp.last !== want.last)
					report_mismatch("last", want.last, rsp.last);
			end
		end
		rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Watchdog: end the run when no channel has moved an item for too long.
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (cfg_valid && cfg_ready))
			stall_cycles <= 0;
		else
			stall_cycles <= stall_cycles + 1;
		if (stall_cycles >= STALL_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Reset registers: define glyph 0xFF with extreme row bytes, print it,
	// and move the cursor with newline and carriage return.
	task automatic test_default_print();
		logic [7:0] pattern [GLYPH_H];
		pattern = '{8'h00, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'h55, 8'h0F, 8'hF0,
			8'h81, 8'h7E, 8'h18, 8'h3C, 8'hC3, 8'h24, 8'h42, 8'h99};
		for (int r = 0; r < GLYPH_H; r++)
			load_row(8'hFF, 4'(r), pattern[r]);
		print_code(8'hFF);
		print_code(8'hFF);
		print_code(CODE_NEWLINE);
		print_code(8'hFF);
		print_code(CODE_RETURN);
		print_code(8'hFF);
	endtask

	// Drive each register to its extremes: clamped pitch, zero rows,
	// one column, the 256-row ceiling, and both color extremes.
	task automatic test_register_extremes();
		set_registers('1, '0, '0);
		print_code(8'hFF);
		print_code(CODE_NEWLINE);
		print_code(8'hFF);
		set_registers('0, '1, '1);
		print_code(8'hFF);
		print_code(8'hFF);
		print_code(CODE_NEWLINE);
		set_registers(LINE_PITCH_W'(8), ROWS_MAX, 32'hA5A5_5A5A);
		print_code(8'hFF);
		print_code(8'hFF);
	endtask

	// Walk the cursor to the bottom row of a short screen at the widest pitch,
	// then shrink the screen so the cursor sits outside it and must wrap on
	// the next move.
	task automatic test_deep_cursor();
		set_registers(LINE_PITCH_W'(PITCH_MAX), TEXT_ROWS_W'(SHORT_ROWS), $urandom);
		print_code(CODE_RETURN);
		while (row_pos != CURSOR_ROW_W'(SHORT_ROWS - 1))
			print_code(CODE_NEWLINE);
		print_code(8'hFF);
		print_code(CODE_NEWLINE);
		print_code(8'hFF);
		while (row_pos != CURSOR_ROW_W'(SHORT_ROWS - 1))
			print_code(CODE_NEWLINE);
		set_registers(LINE_PITCH_W'(16), TEXT_ROWS_W'(4), $urandom);
		print_code(8'hFF);
		print_code(8'hFF);
		print_code(8'hFF);
		set_registers(LINE_PITCH_W'(PITCH_MAX), TEXT_ROWS_W'(SHORT_ROWS), $urandom);
		while (row_pos != CURSOR_ROW_W'(SHORT_ROWS - 1))
			print_code(CODE_NEWLINE);
		set_registers(LINE_PITCH_W'(PITCH_MAX), TEXT_ROWS_W'(2), $urandom);
		print_code(CODE_NEWLINE);
		print_code(8'hFF);
	endtask

	// Mostly prints of fully defined glyphs, with whole glyph definitions,
	// stray row loads and cursor moves mixed in.
	task automatic run_text_traffic(input int count);
		int         pick;
		int         sent;
		logic [7:0] code;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(99);
			if (pick < 5) begin
				code = 8'($urandom_range(255));
				for (int r = 0; r < GLYPH_H; r++)
					load_row(code, 4'(r), 8'($urandom_range(255)));
				sent += GLYPH_H;
			end else if (pick < 17) begin
				load_row(8'($urandom_range(255)), 4'($urandom_range(15)),
					8'($urandom_range(255)));
				sent++;
			end else if (pick < 27) begin
				print_code(CODE_NEWLINE);
				sent++;
			end else if (pick < 33) begin
				print_code(CODE_RETURN);
				sent++;
			end else begin
				print_code(printable[$urandom_range(printable.size() - 1)]);
				sent++;
			end
		end
	endtask

	// One random phase under a given idle mix, with a register change midway.
	task automatic test_random_mix(input int gap_pct, input int stall_pct);
		send_gap_pct   = gap_pct;
		recv_stall_pct = stall_pct;
		set_random_registers();
		run_text_traffic(35);
		set_random_registers();
		run_text_traffic(35);
	endtask

	initial begin
		// Hold reset, then release it on a clock edge
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		test_default_print();
		test_register_extremes();
		test_deep_cursor();
		test_random_mix(33, 54);
		test_random_mix(54, 33);
		test_random_mix(0, 0);

		// Drain every owed row, then give the pipe time to show extras
		settle();
		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
